FILE: rtl/plbu_pkg.sv
package plbu_pkg;

  // side codes of a request
  localparam logic [1:0] SIDE_NULL = 2'd0;
  localparam logic [1:0] SIDE_BID  = 2'd1;
  localparam logic [1:0] SIDE_ASK  = 2'd2;
  localparam logic [1:0] SIDE_RSVD = 2'd3;

  // slot side codes
  localparam logic SLOT_ASK = 1'b0;
  localparam logic SLOT_BID = 1'b1;

  typedef struct packed {
    logic [1:0]          book_side;
    logic signed [63:0]  level_price;
    logic [63:0]         level_quantity;
  } req_t;

  typedef struct packed {
    logic                slot_side;
    logic [3:0]          slot_rank;
    logic                slot_valid;
    logic signed [63:0]  slot_price;
    logic [63:0]         slot_quantity;
    logic                table_full_drop;
    logic                last_slot;
  } slot_t;

  // command broadcast to every cell of one side
  typedef struct packed {
    logic        upd;      // apply an update this cycle
    logic        shift;    // rotate contents one cell toward the head
    logic [63:0] price;
    logic [63:0] qty;
  } cell_cmd_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_ASK,
    ST_BID
  } state_t;

  // true if price a ranks strictly ahead of b (desc = bid side)
  function automatic logic ranks_ahead(input logic [63:0] a, input logic [63:0] b,
                                       input logic desc);
    logic [63:0] ka;
    logic [63:0] kb;
    ka = a ^ 64'h8000_0000_0000_0000;
    kb = b ^ 64'h8000_0000_0000_0000;
    return desc ? (ka > kb) : (ka < kb);
  endfunction

endpackage

FILE: rtl/price_level_book_update.sv
// Price-level book update.
// Request: start with req (side, price, quantity), taken when busy is low.
// Config: cfg_we/cfg_data write shown_levels (reset 10); the user must do so only while idle (not enforced).
// Each side is a chain of LEVELS_PER_SIDE cells, best level in cell 0.
// The UPD state applies the update to every cell of the side at once. Then
// the ask pass steps its rank count up from 0: the chain rotates one cell
// per cycle for the first LEVELS_PER_SIDE ranks, so the contents come back to
// place, and the head is emitted while rank < n. The bid pass does the same.
// A request with side none or 3 is accepted, emits nothing and leaves the block idle.
// The first slot comes in the ASK state that follows UPD. A request occupies
// the block through the UPD, ask and bid states; busy stays high and no new
// request is taken until the block returns to idle.
// Results: slot_strobe marks one slot per cycle, n ask slots then n bid
// slots; last_slot on the final bid slot. The receiver cannot stall.
// Reset empties both sides and sets shown_levels to 10.
module price_level_book_update #(
  parameter int LEVELS_PER_SIDE = 64,
  parameter int MAX_SHOWN       = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  plbu_pkg::req_t  req,
  output logic            busy,
  input  logic            cfg_we,
  input  logic [3:0]      cfg_data,
  output logic            slot_strobe,
  output plbu_pkg::slot_t slot
);

  // a pass covers every cell and at least the 15 ranks a 4-bit count can ask for
  localparam int SPAN  = (LEVELS_PER_SIDE > 16) ? LEVELS_PER_SIDE : 16;
  localparam int CNT_W = $clog2(SPAN);

  plbu_pkg::state_t    state, state_next;
  logic [3:0]          shown_levels;
  logic [3:0]          n_eff;
  logic [CNT_W-1:0]    cnt;
  logic                drop;
  plbu_pkg::req_t      cur;
  plbu_pkg::cell_cmd_t ask_cmd, bid_cmd;
  logic                ask_v, bid_v, ask_drop, bid_drop;
  logic [63:0]         ask_p, ask_q, bid_p, bid_q;
  logic                accept;
  logic                emit;
  logic                last_cnt;
  logic                in_rot;

  assign accept   = start && !busy;
  assign busy     = (state != plbu_pkg::ST_IDLE);
  assign last_cnt = (cnt == CNT_W'(SPAN - 1));
  assign in_rot   = (32'(cnt) < LEVELS_PER_SIDE);

  // effective shown count: clamp to 1..MAX_SHOWN
  always_comb begin
    if (shown_levels == 4'd0) begin
      n_eff = 4'd1;
    end else if (32'(shown_levels) > MAX_SHOWN) begin
      n_eff = 4'(MAX_SHOWN);
    end else begin
      n_eff = shown_levels;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_levels <= 4'd10;
    end else if (cfg_we) begin
      shown_levels <= cfg_data;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      plbu_pkg::ST_IDLE: begin
        if (accept && (req.book_side == plbu_pkg::SIDE_BID ||
                       req.book_side == plbu_pkg::SIDE_ASK)) begin
          state_next = plbu_pkg::ST_UPD;
        end
      end
      plbu_pkg::ST_UPD: state_next = plbu_pkg::ST_ASK;
      plbu_pkg::ST_ASK: if (last_cnt) state_next = plbu_pkg::ST_BID;
      plbu_pkg::ST_BID: if (last_cnt) state_next = plbu_pkg::ST_IDLE;
      default:          state_next = plbu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plbu_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if ((state == plbu_pkg::ST_ASK || state == plbu_pkg::ST_BID) && !last_cnt) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
    if (accept) begin
      cur <= req;
    end
    if (state == plbu_pkg::ST_UPD) begin
      drop <= (cur.book_side == plbu_pkg::SIDE_BID) ? bid_drop : ask_drop;
    end
  end

  // cell commands
  always_comb begin
    ask_cmd.price = cur.level_price;
    ask_cmd.qty   = cur.level_quantity;
    ask_cmd.upd   = (state == plbu_pkg::ST_UPD) && (cur.book_side == plbu_pkg::SIDE_ASK);
    ask_cmd.shift = (state == plbu_pkg::ST_ASK) && in_rot;
    bid_cmd.price = cur.level_price;
    bid_cmd.qty   = cur.level_quantity;
    bid_cmd.upd   = (state == plbu_pkg::ST_UPD) && (cur.book_side == plbu_pkg::SIDE_BID);
    bid_cmd.shift = (state == plbu_pkg::ST_BID) && in_rot;
  end

  plbu_side #(.LEVELS(LEVELS_PER_SIDE)) u_ask (
    .clk(clk), .rst(rst), .desc(1'b0), .cmd(ask_cmd),
    .head_valid(ask_v), .head_price(ask_p), .head_qty(ask_q), .full_drop(ask_drop)
  );

  plbu_side #(.LEVELS(LEVELS_PER_SIDE)) u_bid (
    .clk(clk), .rst(rst), .desc(1'b1), .cmd(bid_cmd),
    .head_valid(bid_v), .head_price(bid_p), .head_qty(bid_q), .full_drop(bid_drop)
  );

  // slot outputs; ranks past the table end are empty
  assign emit = (state == plbu_pkg::ST_ASK || state == plbu_pkg::ST_BID) &&
                (32'(cnt) < 32'(n_eff));

  always_comb begin
    slot_strobe          = emit;
    slot.slot_side       = (state == plbu_pkg::ST_BID) ? plbu_pkg::SLOT_BID
                                                       : plbu_pkg::SLOT_ASK;
    slot.slot_rank       = cnt[3:0];
    slot.table_full_drop = drop;
    slot.last_slot       = (state == plbu_pkg::ST_BID) &&
                           (32'(cnt) + 1 == 32'(n_eff));
    if (state == plbu_pkg::ST_BID) begin
      slot.slot_valid    = in_rot && bid_v;
      slot.slot_price    = (in_rot && bid_v) ? bid_p : '0;
      slot.slot_quantity = (in_rot && bid_v) ? bid_q : '0;
    end else begin
      slot.slot_valid    = in_rot && ask_v;
      slot.slot_price    = (in_rot && ask_v) ? ask_p : '0;
      slot.slot_quantity = (in_rot && ask_v) ? ask_q : '0;
    end
  end

  a_last_bid: assert property (@(posedge clk) disable iff (rst)
    slot_strobe && slot.last_slot |-> slot.slot_side == plbu_pkg::SLOT_BID)
    else $error("last slot not on bid side");
  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    slot_strobe |-> busy)
    else $error("slot while idle");
  a_ask_to_bid: assert property (@(posedge clk) disable iff (rst)
    state == plbu_pkg::ST_ASK && last_cnt |=> state == plbu_pkg::ST_BID)
    else $error("ask rotation did not hand over");

endmodule

FILE: rtl/plbu_cell.sv
// One level slot. On update each cell decides what it holds next from
// itself, the upstream neighbor (index-1) and, on delete, the downstream;
// on rotate it copies the downstream cell so the head walks the table.
module plbu_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                desc,
  input  plbu_pkg::cell_cmd_t cmd,
  input  logic                ins,      // insert enabled (price absent, side not full)
  input  logic                present,  // price already held somewhere in the side
  input  logic                prev_valid,
  input  logic                prev_ahead,   // upstream cell ranks ahead of price
  input  logic [63:0]         prev_price,
  input  logic [63:0]         prev_qty,
  input  logic                nxt_valid,
  input  logic [63:0]         nxt_price,
  input  logic [63:0]         nxt_qty,
  output logic                valid,
  output logic [63:0]         price,
  output logic [63:0]         qty,
  output logic                ahead
);

  logic        valid_next;
  logic [63:0] price_next;
  logic [63:0] qty_next;
  logic        hit;
  logic        del;

  assign ahead = valid && plbu_pkg::ranks_ahead(price, cmd.price, desc);
  assign hit   = valid && (price == cmd.price);
  assign del   = (cmd.qty == '0);

  // next content of this slot
  always_comb begin
    valid_next = valid;
    price_next = price;
    qty_next   = qty;
    if (cmd.shift) begin
      valid_next = nxt_valid;
      price_next = nxt_price;
      qty_next   = nxt_qty;
    end else if (cmd.upd) begin
      if (del) begin
        // table is sorted: cells at or behind the deleted price close the gap
        if (present && !ahead) begin
          valid_next = nxt_valid;
          price_next = nxt_price;
          qty_next   = nxt_qty;
        end
      end else if (hit) begin
        qty_next = cmd.qty;
      end else if (ins) begin
        // insert point: first cell not ranked ahead of the price
        if (prev_ahead && (!valid || !ahead)) begin
          valid_next = 1'b1;
          price_next = cmd.price;
          qty_next   = cmd.qty;
        end else if (!prev_ahead && prev_valid) begin
          valid_next = 1'b1;
          price_next = prev_price;
          qty_next   = prev_qty;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    price <= price_next;
    qty   <= qty_next;
  end

endmodule

FILE: rtl/plbu_side.sv
// One side's table as a chain of cells; cell 0 is the best level.
module plbu_side #(
  parameter int LEVELS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                desc,
  input  plbu_pkg::cell_cmd_t cmd,
  output logic                head_valid,
  output logic [63:0]         head_price,
  output logic [63:0]         head_qty,
  output logic                full_drop   // update would insert into a full side
);

  logic [LEVELS-1:0]       v;
  logic [LEVELS-1:0]       ah;
  logic [LEVELS-1:0][63:0] p;
  logic [LEVELS-1:0][63:0] q;
  logic [LEVELS-1:0]       hit_any;
  logic                    present;

  // price already in table (full side can still overwrite or delete)
  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      hit_any[i] = v[i] && (p[i] == cmd.price);
    end
  end
  assign present   = |hit_any;
  assign full_drop = v[LEVELS-1] && !present && (cmd.qty != '0);

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    plbu_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .desc        (desc),
      .cmd         (cmd),
      .ins         (!full_drop && !present),
      .present     (present),
      .prev_valid  ((i == 0) ? 1'b0 : v[(i == 0) ? 0 : i-1]),
      .prev_ahead  ((i == 0) ? 1'b1 : ah[(i == 0) ? 0 : i-1]),
      .prev_price  (p[(i == 0) ? 0 : i-1]),
      .prev_qty    (q[(i == 0) ? 0 : i-1]),
      .nxt_valid   ((i == LEVELS-1) ? (cmd.shift ? v[0] : 1'b0)
                                    : v[(i == LEVELS-1) ? i : i+1]),
      .nxt_price   ((i == LEVELS-1) ? p[0] : p[(i == LEVELS-1) ? i : i+1]),
      .nxt_qty     ((i == LEVELS-1) ? q[0] : q[(i == LEVELS-1) ? i : i+1]),
      .valid       (v[i]),
      .price       (p[i]),
      .qty         (q[i]),
      .ahead       (ah[i])
    );
  end

  assign head_valid = v[0];
  assign head_price = p[0];
  assign head_qty   = q[0];

endmodule
